[rtl/core/bankers_safe_allocator_macros.svh]
// assertion helpers used by the checker file
`ifndef BANKERS_SAFE_ALLOCATOR_MACROS_SVH
`define BANKERS_SAFE_ALLOCATOR_MACROS_SVH

// cause in this cycle, effect in the next
`define BSA_ASSERT_NEXT(lbl, cause, effect) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
    else $error("bsa check failed: next-cycle rule");

// cause and effect in the same cycle
`define BSA_ASSERT_SAME(lbl, cause, effect) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |-> (effect)) \
    else $error("bsa check failed: same-cycle rule");

`endif

[rtl/core/bsa_pkg.sv]
package bsa_pkg;

  localparam int AMT_W      = 16;
  localparam int ID_W       = 16;
  localparam int TOT_W      = 15;
  localparam int OP_W       = 2;
  localparam int SLOT_W     = 3;
  localparam int STATUS_W   = 3;
  localparam int RCOUNT_W   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_RES_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BASE = 3'd1;
  localparam logic [RCOUNT_W-1:0]  RCOUNT_RESET   = 3'd4;

  typedef enum logic [OP_W-1:0] {
    OP_REGISTER = 2'd0,
    OP_REQUEST  = 2'd1,
    OP_CLOSE    = 2'd2,
    OP_END      = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACK       = 3'd0,
    ST_WAIT      = 3'd1,
    ST_INVALID   = 3'd2,
    ST_EXISTS    = 3'd3,
    ST_NOTREG    = 3'd4,
    ST_HOLDING   = 3'd5,
    ST_CONNECTED = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DECIDE,
    S_WALK_RD,
    S_WALK_EV,
    S_WALK_END
  } state_t;

  typedef struct packed {
    logic latch;
    logic decide;
    logic walk_rd;
    logic eval;
    logic step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic need_walk;
    logic eligible;
    logic walk_fin;
  } dp_sts_t;

endpackage

[rtl/core/bsa_ram.sv]
module bsa_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/bsa_datapath.sv]
module bsa_datapath #(
  parameter int MAX_CLIENTS   = 8,
  parameter int MAX_RESOURCES = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bsa_pkg::dp_cmd_t                    cmd,
  output bsa_pkg::dp_sts_t                    sts,
  input  logic [bsa_pkg::OP_W-1:0]            in_operation,
  input  logic [bsa_pkg::SLOT_W-1:0]          in_slot,
  input  logic [bsa_pkg::ID_W-1:0]            in_client_id,
  input  logic signed [bsa_pkg::AMT_W-1:0]    amt_in [MAX_RESOURCES],
  input  logic                                cfg_we,
  input  logic [bsa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bsa_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic [bsa_pkg::STATUS_W-1:0]        out_status
);
  import bsa_pkg::*;

  localparam int SW    = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int CW    = $clog2(MAX_CLIENTS + 1);
  localparam int AW    = $clog2(MAX_CLIENTS + 1) + 17;
  localparam int ROW_W = 2 * MAX_RESOURCES * AMT_W;

  // latched request
  op_t                     op_r;
  logic [SLOT_W-1:0]       slot_r;
  logic [ID_W-1:0]         cid_r;
  logic signed [AMT_W-1:0] amt_r [MAX_RESOURCES];

  // slot table
  logic [MAX_CLIENTS-1:0]  active_r, here_r;
  logic [ID_W-1:0]         owner_r [MAX_CLIENTS];
  logic signed [AW-1:0]    avail_r [MAX_RESOURCES];
  logic [RCOUNT_W-1:0]     rcount_r;
  logic [CW-1:0]           count_r;
  logic                    ended_r;

  // walk state
  logic signed [AW-1:0]    work_r  [MAX_RESOURCES];
  logic signed [AMT_W-1:0] fresh_r [MAX_RESOURCES];
  logic signed [AMT_W-1:0] maxs_r  [MAX_RESOURCES];
  logic [MAX_CLIENTS-1:0]  done_r;
  logic                    progress_r;
  logic [SW-1:0]           c_r;
  status_t                 status_r;

  // ram
  logic                    ram_we;
  logic [SW-1:0]           ram_waddr, ram_raddr;
  logic [ROW_W-1:0]        ram_wdata, ram_rdata;

  logic [SW-1:0]           s_idx;
  logic                    s_ok, dup, holding, bad, safe, fits, last, progress_eff;
  logic                    need_walk;
  logic [MAX_RESOURCES-1:0] kmask;
  logic signed [AMT_W-1:0] row_max   [MAX_RESOURCES];
  logic signed [AMT_W-1:0] row_alloc [MAX_RESOURCES];
  logic signed [AMT_W-1:0] alloc_c   [MAX_RESOURCES];
  logic signed [17:0]      sum_v     [MAX_RESOURCES];
  logic signed [16:0]      need      [MAX_RESOURCES];
  status_t                 status_dec;

  bsa_ram #(.WIDTH(ROW_W), .DEPTH(MAX_CLIENTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign s_idx     = SW'(slot_r);
  assign s_ok      = (32'(slot_r) < MAX_CLIENTS);
  assign ram_raddr = cmd.walk_rd ? c_r : s_idx;
  assign ram_waddr = s_idx;
  assign last      = (c_r == SW'(MAX_CLIENTS - 1));
  assign safe      = &(~active_r | done_r);

  always_comb begin
    dup     = active_r[s_idx];
    holding = 1'b0;
    bad     = 1'b0;
    fits    = 1'b1;
    for (int c = 0; c < MAX_CLIENTS; c++) begin
      if (active_r[c] && owner_r[c] == cid_r) dup = 1'b1;
    end
    for (int k = 0; k < MAX_RESOURCES; k++) begin
      kmask[k]     = (k == 0) || (32'(rcount_r) > k);
      row_max[k]   = $signed(ram_rdata[k*AMT_W +: AMT_W]);
      row_alloc[k] = $signed(ram_rdata[(MAX_RESOURCES+k)*AMT_W +: AMT_W]);
      sum_v[k]     = 18'(row_alloc[k]) + 18'(amt_r[k]);
      alloc_c[k]   = (c_r == s_idx) ? fresh_r[k] : row_alloc[k];
      need[k]      = 17'(row_max[k]) - 17'(alloc_c[k]);
      if (kmask[k] && row_alloc[k] != '0) holding = 1'b1;
      if (kmask[k] && (sum_v[k] > 18'(row_max[k]) || sum_v[k] < 18'sd0)) bad = 1'b1;
      if (kmask[k] && AW'(need[k]) > work_r[k]) fits = 1'b0;
    end
  end

  always_comb begin
    status_dec = ST_ACK;
    need_walk  = 1'b0;
    priority if (ended_r || !s_ok) begin
      status_dec = ST_INVALID;
    end else begin
      unique case (op_r)
        OP_REGISTER: if (dup) status_dec = ST_EXISTS;
        OP_REQUEST: begin
          priority if (!here_r[s_idx]) status_dec = ST_NOTREG;
          else if (bad) status_dec = ST_INVALID;
          else need_walk = 1'b1;
        end
        OP_CLOSE: if (active_r[s_idx] && holding) status_dec = ST_HOLDING;
        OP_END: if (count_r != '0) status_dec = ST_CONNECTED;
        default: status_dec = ST_INVALID;
      endcase
    end
  end

  assign sts.need_walk = need_walk;
  assign progress_eff  = progress_r | (cmd.eval & fits);
  assign sts.eligible  = active_r[c_r] & ~done_r[c_r];
  assign sts.walk_fin  = last & ~progress_eff;

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    if (cmd.decide && !sts.need_walk && status_dec == ST_ACK && op_r == OP_REGISTER
        && !ended_r && s_ok) begin
      ram_we = 1'b1;
      for (int k = 0; k < MAX_RESOURCES; k++) begin
        ram_wdata[k*AMT_W +: AMT_W] = amt_r[k];
      end
    end else if (cmd.commit && safe) begin
      ram_we = 1'b1;
      for (int k = 0; k < MAX_RESOURCES; k++) begin
        ram_wdata[k*AMT_W +: AMT_W]                   = maxs_r[k];
        ram_wdata[(MAX_RESOURCES+k)*AMT_W +: AMT_W]   = fresh_r[k];
      end
    end
  end

  // request latch and walk registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= op_t'(in_operation);
      slot_r <= in_slot;
      cid_r  <= in_client_id;
      for (int k = 0; k < MAX_RESOURCES; k++) amt_r[k] <= amt_in[k];
    end
    if (cmd.decide) begin
      done_r     <= '0;
      progress_r <= 1'b0;
      c_r        <= '0;
      for (int k = 0; k < MAX_RESOURCES; k++) begin
        maxs_r[k]  <= row_max[k];
        fresh_r[k] <= kmask[k] ? sum_v[k][AMT_W-1:0] : row_alloc[k];
        work_r[k]  <= kmask[k] ? (avail_r[k] - AW'(amt_r[k])) : avail_r[k];
      end
      status_r <= status_dec;
    end
    if (cmd.eval && fits) begin
      done_r[c_r] <= 1'b1;
      for (int k = 0; k < MAX_RESOURCES; k++) begin
        if (kmask[k]) work_r[k] <= work_r[k] + AW'(alloc_c[k]);
      end
    end
    if (cmd.step) begin
      if (last) begin
        if (progress_eff) begin
          c_r        <= '0;
          progress_r <= 1'b0;
        end
      end else begin
        c_r        <= c_r + SW'(1);
        progress_r <= progress_eff;
      end
    end
    if (cmd.commit) begin
      status_r <= safe ? ST_ACK : ST_WAIT;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide && !sts.need_walk && !ended_r && s_ok && op_r == OP_REGISTER && !dup) begin
      owner_r[s_idx] <= cid_r;
    end
  end

  // slot table, counters and available units
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      here_r   <= '0;
      count_r  <= '0;
      ended_r  <= 1'b0;
      rcount_r <= RCOUNT_RESET;
      for (int k = 0; k < MAX_RESOURCES; k++) avail_r[k] <= AW'(1);
    end else begin
      if (cfg_we && count_r == '0) begin
        if (cfg_index == CFG_RES_COUNT) rcount_r <= cfg_data[RCOUNT_W-1:0];
        for (int k = 0; k < MAX_RESOURCES; k++) begin
          if (cfg_index == CFG_TOTAL_BASE + CFG_IDX_W'(k)) begin
            avail_r[k] <= AW'({1'b0, cfg_data[TOT_W-1:0]});
          end
        end
      end
      if (cmd.decide && !sts.need_walk && !ended_r && s_ok) begin
        unique case (op_r)
          OP_REGISTER: begin
            if (dup) begin
              here_r[s_idx] <= 1'b0;
            end else begin
              active_r[s_idx] <= 1'b1;
              here_r[s_idx]   <= 1'b1;
              count_r         <= count_r + CW'(1);
            end
          end
          OP_CLOSE: begin
            if (!active_r[s_idx]) begin
              here_r[s_idx] <= 1'b0;
            end else if (!holding) begin
              active_r[s_idx] <= 1'b0;
              here_r[s_idx]   <= 1'b0;
              if (count_r != '0) count_r <= count_r - CW'(1);
            end
          end
          OP_END: if (count_r == '0) ended_r <= 1'b1;
          default: ;
        endcase
      end
      if (cmd.commit && safe) begin
        for (int k = 0; k < MAX_RESOURCES; k++) begin
          if (kmask[k]) avail_r[k] <= avail_r[k] - AW'(amt_r[k]);
        end
      end
    end
  end

  assign out_status = status_r;

endmodule

[rtl/core/bsa_ctrl.sv]
module bsa_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  bsa_pkg::dp_sts_t sts,
  output bsa_pkg::dp_cmd_t cmd,
  output logic             busy,
  output logic             out_valid
);
  import bsa_pkg::*;

  state_t state_r, state_nxt;
  logic   valid_r, valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    valid_nxt = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_DECIDE;
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (sts.need_walk) begin
          state_nxt = S_WALK_RD;
        end else begin
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_WALK_RD: begin
        cmd.walk_rd = 1'b1;
        if (sts.eligible) begin
          state_nxt = S_WALK_EV;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = sts.walk_fin ? S_WALK_END : S_WALK_RD;
        end
      end
      S_WALK_EV: begin
        cmd.eval  = 1'b1;
        cmd.step  = 1'b1;
        state_nxt = sts.walk_fin ? S_WALK_END : S_WALK_RD;
      end
      S_WALK_END: begin
        cmd.commit = 1'b1;
        valid_nxt  = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = valid_r;

endmodule

[rtl/core/bankers_safe_allocator.sv]
// channel   ports                                             handshake
// request   in_operation in_slot in_client_id in_amount_0..3  start high, busy low
// result    out_status                                        out_valid, one cycle
// config    cfg_index cfg_data                                cfg_we, no wait
//
// register, close, end and rejected requests pass the latch, READ and DECIDE states
// before the registered result strobe; a checked request adds the safety walk, where
// a skipped slot takes a read state and a tested slot a read and an evaluate state
// (registered read of the claim ram), up to MAX_CLIENTS + 1 passes (the last one
// finds no progress), then a commit state before the result strobe
// reset is synchronous, active low; the result side cannot stall the block
module bankers_safe_allocator #(
  parameter int MAX_CLIENTS   = 8,
  parameter int MAX_RESOURCES = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // request channel
  input  logic                               start,
  output logic                               busy,
  input  logic [bsa_pkg::OP_W-1:0]           in_operation,
  input  logic [bsa_pkg::SLOT_W-1:0]         in_slot,
  input  logic [bsa_pkg::ID_W-1:0]           in_client_id,
  input  logic signed [bsa_pkg::AMT_W-1:0]   in_amount_0,
  input  logic signed [bsa_pkg::AMT_W-1:0]   in_amount_1,
  input  logic signed [bsa_pkg::AMT_W-1:0]   in_amount_2,
  input  logic signed [bsa_pkg::AMT_W-1:0]   in_amount_3,
  // result channel
  output logic                               out_valid,
  output logic [bsa_pkg::STATUS_W-1:0]       out_status,
  // config port
  input  logic                               cfg_we,
  input  logic [bsa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bsa_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import bsa_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // amounts of the kinds that exist in this build
  logic signed [AMT_W-1:0] amt_all [4];
  logic signed [AMT_W-1:0] amt_in  [MAX_RESOURCES];

  assign amt_all[0] = in_amount_0;
  assign amt_all[1] = in_amount_1;
  assign amt_all[2] = in_amount_2;
  assign amt_all[3] = in_amount_3;

  always_comb begin
    for (int k = 0; k < MAX_RESOURCES; k++) amt_in[k] = amt_all[k];
  end

  // sequencer: latch, read the slot row, decide, then the safety walk if needed
  bsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // slot table, claim/allocation ram, available units and the walk registers
  bsa_datapath #(
    .MAX_CLIENTS   (MAX_CLIENTS),
    .MAX_RESOURCES (MAX_RESOURCES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_operation (in_operation),
    .in_slot      (in_slot),
    .in_client_id (in_client_id),
    .amt_in       (amt_in),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_status   (out_status)
  );

endmodule

[rtl/core/bsa_checker.sv]
`include "bankers_safe_allocator_macros.svh"

module bsa_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // a request taken always makes the block busy
  `BSA_ASSERT_NEXT(a_take_busy, start && !busy, busy)
  // results never come back to back
  `BSA_ASSERT_NEXT(a_one_strobe, out_valid, !out_valid)
  // the result strobe marks the end of the busy period
  `BSA_ASSERT_SAME(a_valid_idle, out_valid, !busy)
  `BSA_ASSERT_SAME(a_fall_valid, $fell(busy), out_valid)

endmodule

bind bankers_safe_allocator bsa_checker u_bsa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
